// ===== rtl/core/kcar_pkg.sv =====
package kcar_pkg;

	localparam int unsigned KeyW  = 3;
	localparam int unsigned KeysN = 6;
	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned CmdW  = 3;
	localparam int unsigned IdxW  = 2;

	// input tdata: key, event_req, now, ready_req, zero fill
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 8;

	localparam logic [IdxW-1:0] REG_INITIAL_DELAY   = 2'd0;
	localparam logic [IdxW-1:0] REG_REPEAT_INTERVAL = 2'd1;
	localparam logic [IdxW-1:0] REG_HOLD_LIMIT      = 2'd2;

	localparam logic [CfgW-1:0] INITIAL_DELAY_RST   = 16'd400;
	localparam logic [CfgW-1:0] REPEAT_INTERVAL_RST = 16'd125;
	localparam logic [CfgW-1:0] HOLD_LIMIT_RST      = 16'd10000;

	localparam logic [1:0] EV_PRESS   = 2'd0;
	localparam logic [1:0] EV_RELEASE = 2'd1;
	localparam logic [1:0] EV_OTHER   = 2'd2;
	localparam logic [1:0] EV_LONG    = 2'd3;

	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [KeyW-1:0] KEY_EXIT = 3'd5;
	localparam logic [KeyW-1:0] KEY_MAX  = 3'd5;

	localparam logic [CmdW-1:0] CMD_NONE = 3'd0;

	typedef struct packed {
		logic [KeyW-1:0]  key;
		logic [1:0]       event_req;
		logic [TimeW-1:0] now;
		logic             ready_req;
	} in_word_t;

	// fixed command for a fresh press of each key
	function automatic logic [CmdW-1:0] key_cmd(input logic [KeyW-1:0] k);
		logic [CmdW-1:0] c;
		case (k)
			3'd0:    c = 3'd4;
			3'd1:    c = 3'd5;
			3'd2:    c = 3'd2;
			3'd3:    c = 3'd3;
			3'd4:    c = 3'd1;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/key_command_auto_repeat.sv =====
// Key command auto-repeat. Each input word is a key event (tuser low) or a
// millisecond tick (tuser high) and yields exactly one output word with a
// command code (0 = none) and an exit request flag. A fresh press of keys 0..5
// gives its fixed command; keys 0 and 1 repeat on ticks after initial_delay
// every repeat_interval ms until release or hold_limit ms after the press.
// A low ready flag clears held keys and the repeat. One word per clock is
// sustained: an input register feeds combinational logic that updates the key
// state and loads the output register; only output backpressure stalls the
// input. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block itself does
// not enforce.
module key_command_auto_repeat (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kcar_pkg::IdxW-1:0]           cfg_index,
	input  logic [kcar_pkg::CfgW-1:0]           cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// key[2:0], event_req[4:3], now[36:5], ready_req[37], zero[39:38]
	input  logic [kcar_pkg::InDataW-1:0]        s_tdata,
	// kind[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// command[2:0], exit_request[3], zero[7:4]
	output logic [kcar_pkg::OutDataW-1:0]       m_tdata
);

	logic [kcar_pkg::CfgW-1:0] initial_delay_q, repeat_interval_q, hold_limit_q;

	logic                       valid_s1;
	logic                       kind_s1;
	kcar_pkg::in_word_t         word_s1;

	logic [kcar_pkg::KeysN-1:0] held_q;
	logic                       rep_active_q;
	logic                       rep_key_q;
	logic [kcar_pkg::TimeW-1:0] press_time_q;
	logic [kcar_pkg::TimeW-1:0] next_time_q;

	logic                       out_valid_q;
	logic [kcar_pkg::CmdW-1:0]  out_cmd_q;
	logic                       out_exit_q;

	logic out_free, fire;

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(kcar_pkg::OutDataW - kcar_pkg::CmdW - 1){1'b0}}, out_exit_q, out_cmd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q   <= kcar_pkg::INITIAL_DELAY_RST;
			repeat_interval_q <= kcar_pkg::REPEAT_INTERVAL_RST;
			hold_limit_q      <= kcar_pkg::HOLD_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kcar_pkg::REG_INITIAL_DELAY:   initial_delay_q   <= cfg_data;
				kcar_pkg::REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				kcar_pkg::REG_HOLD_LIMIT:      hold_limit_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1           <= s_tuser;
			word_s1.key       <= s_tdata[2:0];
			word_s1.event_req <= s_tdata[4:3];
			word_s1.now       <= s_tdata[36:5];
			word_s1.ready_req <= s_tdata[37];
		end
	end

	// item logic
	logic [kcar_pkg::KeysN-1:0] held_d;
	logic                       rep_active_d, rep_key_d;
	logic [kcar_pkg::TimeW-1:0] press_time_d, next_time_d;
	logic [kcar_pkg::CmdW-1:0]  cmd_d;
	logic                       exit_d;
	logic [kcar_pkg::TimeW-1:0] since_press, since_due;
	logic                       rep_held;

	assign since_press = word_s1.now - press_time_q;
	assign since_due   = word_s1.now - next_time_q;
	assign rep_held    = held_q[{2'b00, rep_key_q}];

	always_comb begin
		held_d       = held_q;
		rep_active_d = rep_active_q;
		rep_key_d    = rep_key_q;
		press_time_d = press_time_q;
		next_time_d  = next_time_q;
		cmd_d        = kcar_pkg::CMD_NONE;
		exit_d       = 1'b0;

		if (kind_s1 == kcar_pkg::KIND_KEY) begin
			if (word_s1.key > kcar_pkg::KEY_MAX) begin
				// unknown key: nothing happens
			end else if (word_s1.key == kcar_pkg::KEY_EXIT &&
			             word_s1.event_req == kcar_pkg::EV_LONG) begin
				exit_d = 1'b1;
			end else if (!word_s1.ready_req) begin
				held_d       = '0;
				rep_active_d = 1'b0;
				rep_key_d    = 1'b0;
				press_time_d = '0;
				next_time_d  = '0;
			end else if (word_s1.event_req == kcar_pkg::EV_RELEASE) begin
				held_d[word_s1.key] = 1'b0;
				if (rep_active_q && word_s1.key < 3'd2 && word_s1.key[0] == rep_key_q)
					rep_active_d = 1'b0;
			end else if (word_s1.event_req == kcar_pkg::EV_PRESS && !held_q[word_s1.key]) begin
				held_d[word_s1.key] = 1'b1;
				cmd_d = kcar_pkg::key_cmd(word_s1.key);
				if (word_s1.key < 3'd2) begin
					rep_active_d = 1'b1;
					rep_key_d    = word_s1.key[0];
					press_time_d = word_s1.now;
					next_time_d  = word_s1.now + {16'd0, initial_delay_q};
				end
			end
		end else begin
			if (!word_s1.ready_req) begin
				held_d       = '0;
				rep_active_d = 1'b0;
				rep_key_d    = 1'b0;
				press_time_d = '0;
				next_time_d  = '0;
			end else if (rep_active_q && rep_held) begin
				if (since_press >= {16'd0, hold_limit_q}) begin
					rep_active_d = 1'b0;
				end else if (!since_due[kcar_pkg::TimeW-1]) begin
					next_time_d = word_s1.now + {16'd0, repeat_interval_q};
					cmd_d       = kcar_pkg::key_cmd({2'b00, rep_key_q});
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			rep_active_q <= 1'b0;
			rep_key_q    <= 1'b0;
			press_time_q <= '0;
			next_time_q  <= '0;
		end else if (fire) begin
			held_q       <= held_d;
			rep_active_q <= rep_active_d;
			rep_key_q    <= rep_key_d;
			press_time_q <= press_time_d;
			next_time_q  <= next_time_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_cmd_q  <= cmd_d;
			out_exit_q <= exit_d;
		end
	end

endmodule
